FILE: sv/cfbr_pkg.sv
// ----------------------------------------------------------------------------
// cfbr_pkg
// Shared types, constants and the CRC byte step for the framed byte receiver.
// ----------------------------------------------------------------------------
package cfbr_pkg;

   // largest payload a frame may carry
   localparam int MaxPayload  = 32;
   // most results one received byte may cause
   localparam int MaxResults  = 64;
   // stream ring: holds the current frame window plus the newest byte
   localparam int RingDepth   = 64;
   localparam int RingAw      = $clog2(RingDepth);
   localparam int CountW      = $clog2(MaxPayload + 1);
   localparam int IndexW      = $clog2(MaxPayload);
   localparam int ResCntW     = $clog2(MaxResults + 1);
   localparam logic [15:0] TopBit = 16'h8000;

   // result kinds
   localparam logic [1:0] KindPayload = 2'd0;
   localparam logic [1:0] KindEmpty   = 2'd1;
   localparam logic [1:0] KindBurst   = 2'd2;

   // register indexes
   localparam logic [2:0] RegPreambleFirst  = 3'd0;
   localparam logic [2:0] RegPreambleSecond = 3'd1;
   localparam logic [2:0] RegCrcStart       = 3'd2;
   localparam logic [2:0] RegCrcPolynomial  = 3'd3;
   localparam logic [2:0] RegPayloadLimit   = 3'd4;
   localparam logic [2:0] RegBurstLimit     = 3'd5;

   // configuration register set
   typedef struct packed {
      logic [7:0]  preamble_first;
      logic [7:0]  preamble_second;
      logic [15:0] crc_start;
      logic [15:0] crc_polynomial;
      logic [5:0]  payload_limit;
      logic [15:0] burst_limit;
   } cfg_type;

   // control of the shared crc unit
   typedef struct packed {
      logic init;
      logic step;
   } crc_ctl_type;

   // one msb-first crc-16 byte update
   function automatic logic [15:0] crc_byte(input logic [15:0] crc,
                                            input logic [15:0] poly,
                                            input logic [7:0]  data);
      logic [15:0] c;
      c = crc ^ {data, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if ((c & TopBit) != 16'h0000) begin
            c = {c[14:0], 1'b0} ^ poly;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

FILE: sv/cfbr_ram.sv
// ----------------------------------------------------------------------------
// cfbr_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module cfbr_ram #(
   parameter int Width = 8,
   parameter int Depth = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/cfbr_crc_unit.sv
// ----------------------------------------------------------------------------
// cfbr_crc_unit
// Shared crc-16 register, loaded with the start value and stepped one byte
// per use.
// ----------------------------------------------------------------------------
module cfbr_crc_unit
   import cfbr_pkg::*;
(
   input  logic        clock,
   input  crc_ctl_type ctl,
   input  logic [15:0] start,
   input  logic [15:0] poly,
   input  logic [7:0]  data,
   output logic [15:0] crc
);

   logic [15:0] crc_ff;
   logic [15:0] crc_in;

   // load or step the checksum
   always_comb begin
      crc_in = crc_ff;
      if (ctl.init) begin
         crc_in = start;
      end else if (ctl.step) begin
         crc_in = crc_byte(crc_ff, poly, data);
      end
   end

   always_ff @(posedge clock) begin
      crc_ff <= crc_in;
   end

   assign crc = crc_ff;

endmodule

FILE: sv/cfbr_csr.sv
// ----------------------------------------------------------------------------
// cfbr_csr
// Configuration registers of the framed byte receiver.
// ----------------------------------------------------------------------------
module cfbr_csr
   import cfbr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata,
   output cfg_type     cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            RegPreambleFirst:  cfg_in.preamble_first  = csr_wdata[7:0];
            RegPreambleSecond: cfg_in.preamble_second = csr_wdata[7:0];
            RegCrcStart:       cfg_in.crc_start       = csr_wdata;
            RegCrcPolynomial:  cfg_in.crc_polynomial  = csr_wdata;
            RegPayloadLimit:   cfg_in.payload_limit   = csr_wdata[5:0];
            RegBurstLimit:     cfg_in.burst_limit     = csr_wdata;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.preamble_first  <= 8'hAA;
         cfg_ff.preamble_second <= 8'h55;
         cfg_ff.crc_start       <= 16'hFFFF;
         cfg_ff.crc_polynomial  <= 16'h1021;
         cfg_ff.payload_limit   <= 6'(MaxPayload);
         cfg_ff.burst_limit     <= 16'd5;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

endmodule

FILE: sv/crc_framed_byte_receiver.sv
// ----------------------------------------------------------------------------
// crc_framed_byte_receiver
// Finds preamble/id/length/payload/crc-16 frames in a received byte stream
// and hands out payload bytes, empty-frame markers and burst-error reports.
//
//   channel  direction  handshake          payload
//   req      in         req_valid/stall    rx_byte
//   rsp      out        rsp_valid/stall    kind .. last
//   csr      in         csr_valid/ready    csr_index, csr_wdata
//
// A plain stream byte goes through accept, fetch, scan and an empty check
// before the next accept; the frame check adds a read and an update step per
// byte of id, length and payload plus one compare step, and each payload result
// a read and a write step; a failed frame replays up to 37 stored bytes from
// the stream ring, one memory read port setting the pace. req_stall stays high
// until all replay work is done.
// Synchronous reset clears control state; ring contents need no clearing.
// A stalled rsp channel holds the sequencer in its check or emit step.
// ----------------------------------------------------------------------------
module crc_framed_byte_receiver
   import cfbr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_frame_id,
   output logic [5:0]  rsp_frame_length,
   output logic [4:0]  rsp_byte_index,
   output logic [7:0]  rsp_payload_byte,
   output logic [15:0] rsp_error_count,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   typedef enum logic [2:0] {
      SEQ_IDLE, SEQ_FETCH, SEQ_BYTE, SEQ_CRC_RD, SEQ_CRC_UP, SEQ_CHECK,
      SEQ_EM_RD, SEQ_EM_WR
   } seq_type;

   typedef enum logic [2:0] {
      SCAN_WAIT1, SCAN_WAIT2, SCAN_ID, SCAN_LEN, SCAN_PAY, SCAN_CLO, SCAN_CHI
   } scan_type;

   cfg_type     cfg;
   crc_ctl_type crc_ctl;
   logic [15:0] crc_value;

   seq_type     seq_ff, seq_in;
   scan_type    scan_ff, scan_in;
   logic [RingAw-1:0]  wr_ff, wr_in, rd_ff, rd_in, fs_ff, fs_in;
   logic [7:0]  held_id_ff, held_id_in;
   logic [7:0]  held_len_ff, held_len_in;
   logic [CountW-1:0]  pay_cnt_ff, pay_cnt_in;
   logic [15:0] rx_check_ff, rx_check_in;
   logic [15:0] fail_ff, fail_in;
   logic [CountW:0]    step_ff, step_in;
   logic [ResCntW-1:0] res_cnt_ff, res_cnt_in;

   logic        out_valid_ff, out_valid_in;
   logic [1:0]  out_kind_ff, out_kind_in;
   logic [7:0]  out_id_ff, out_id_in;
   logic [5:0]  out_len_ff, out_len_in;
   logic [4:0]  out_idx_ff, out_idx_in;
   logic [7:0]  out_byte_ff, out_byte_in;
   logic [15:0] out_err_ff, out_err_in;
   logic        out_last_ff, out_last_in;

   logic              ram_we, ram_re;
   logic [RingAw-1:0] ram_raddr;
   logic [7:0]        ram_rdata;

   logic [5:0]  lim;
   logic [5:0]  len6;
   logic        slot_free, emit_ok;
   logic [15:0] fail_next;

   cfbr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   cfbr_ram #(.Width(8), .Depth(RingDepth)) u_ring (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wr_ff),
      .wr_data (req_rx_byte),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   cfbr_crc_unit u_crc (
      .clock (clock),
      .ctl   (crc_ctl),
      .start (cfg.crc_start),
      .poly  (cfg.crc_polynomial),
      .data  (ram_rdata),
      .crc   (crc_value)
   );

   // effective payload limit and helpers
   assign lim       = (cfg.payload_limit > 6'(MaxPayload)) ? 6'(MaxPayload)
                                                          : cfg.payload_limit;
   assign len6      = held_len_ff[5:0];
   assign slot_free = !out_valid_ff || !rsp_stall;
   assign emit_ok   = res_cnt_ff < ResCntW'(MaxResults);
   assign fail_next = fail_ff + 16'd1;

   // sequencer
   always_comb begin
      seq_in      = seq_ff;
      scan_in     = scan_ff;
      wr_in       = wr_ff;
      rd_in       = rd_ff;
      fs_in       = fs_ff;
      held_id_in  = held_id_ff;
      held_len_in = held_len_ff;
      pay_cnt_in  = pay_cnt_ff;
      rx_check_in = rx_check_ff;
      fail_in     = fail_ff;
      step_in     = step_ff;
      res_cnt_in  = res_cnt_ff;
      out_valid_in = out_valid_ff;
      out_kind_in  = out_kind_ff;
      out_id_in    = out_id_ff;
      out_len_in   = out_len_ff;
      out_idx_in   = out_idx_ff;
      out_byte_in  = out_byte_ff;
      out_err_in   = out_err_ff;
      out_last_in  = out_last_ff;
      ram_we      = 1'b0;
      ram_re      = 1'b0;
      ram_raddr   = rd_ff;
      crc_ctl     = '0;

      // output register drains
      if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end

      unique case (seq_ff)
         SEQ_IDLE: begin
            if (req_valid) begin
               ram_we     = 1'b1;
               wr_in      = wr_ff + RingAw'(1);
               res_cnt_in = '0;
               seq_in     = SEQ_FETCH;
            end
         end
         SEQ_FETCH: begin
            if (rd_ff == wr_ff) begin
               seq_in = SEQ_IDLE;
            end else begin
               ram_re    = 1'b1;
               ram_raddr = rd_ff;
               seq_in    = SEQ_BYTE;
            end
         end
         SEQ_BYTE: begin
            rd_in  = rd_ff + RingAw'(1);
            seq_in = SEQ_FETCH;
            unique case (scan_ff)
               SCAN_WAIT2: begin
                  if (ram_rdata == cfg.preamble_second) begin
                     scan_in = SCAN_ID;
                  end else if (ram_rdata == cfg.preamble_first) begin
                     fs_in   = rd_ff;
                     scan_in = SCAN_WAIT2;
                  end else begin
                     scan_in = SCAN_WAIT1;
                  end
               end
               SCAN_ID: begin
                  held_id_in = ram_rdata;
                  scan_in    = SCAN_LEN;
               end
               SCAN_LEN: begin
                  held_len_in = ram_rdata;
                  pay_cnt_in  = '0;
                  if (ram_rdata > {2'b00, lim}) begin
                     // overlong: replay from the byte after the frame start
                     rd_in   = fs_ff + RingAw'(1);
                     scan_in = SCAN_WAIT1;
                  end else if (ram_rdata != 8'd0) begin
                     scan_in = SCAN_PAY;
                  end else begin
                     scan_in = SCAN_CLO;
                  end
               end
               SCAN_PAY: begin
                  pay_cnt_in = pay_cnt_ff + CountW'(1);
                  if ({2'b00, pay_cnt_ff + CountW'(1)} >= held_len_ff) begin
                     scan_in = SCAN_CLO;
                  end
               end
               SCAN_CLO: begin
                  rx_check_in = {8'h00, ram_rdata};
                  scan_in     = SCAN_CHI;
               end
               SCAN_CHI: begin
                  rx_check_in = {ram_rdata, rx_check_ff[7:0]};
                  crc_ctl.init = 1'b1;
                  step_in      = '0;
                  scan_in      = SCAN_WAIT1;
                  seq_in       = SEQ_CRC_RD;
               end
               default: begin
                  if (ram_rdata == cfg.preamble_first) begin
                     fs_in   = rd_ff;
                     scan_in = SCAN_WAIT2;
                  end else begin
                     scan_in = SCAN_WAIT1;
                  end
               end
            endcase
         end
         SEQ_CRC_RD: begin
            ram_re    = 1'b1;
            ram_raddr = fs_ff + RingAw'(2) + step_ff[RingAw-1:0];
            seq_in    = SEQ_CRC_UP;
         end
         SEQ_CRC_UP: begin
            crc_ctl.step = 1'b1;
            step_in      = step_ff + (CountW+1)'(1);
            if (step_ff + (CountW+1)'(1) == (CountW+1)'(len6) + (CountW+1)'(2)) begin
               seq_in = SEQ_CHECK;
            end else begin
               seq_in = SEQ_CRC_RD;
            end
         end
         SEQ_CHECK: begin
            if (crc_value == rx_check_ff) begin
               fail_in = '0;
               if (len6 == 6'd0) begin
                  if (!emit_ok) begin
                     seq_in = SEQ_FETCH;
                  end else if (slot_free) begin
                     out_valid_in = 1'b1;
                     out_kind_in  = KindEmpty;
                     out_id_in    = held_id_ff;
                     out_len_in   = '0;
                     out_idx_in   = '0;
                     out_byte_in  = '0;
                     out_err_in   = '0;
                     out_last_in  = 1'b1;
                     res_cnt_in   = res_cnt_ff + ResCntW'(1);
                     seq_in       = SEQ_FETCH;
                  end
               end else begin
                  step_in = '0;
                  seq_in  = SEQ_EM_RD;
               end
            end else if (fail_next >= cfg.burst_limit) begin
               if (!emit_ok || slot_free) begin
                  if (emit_ok) begin
                     out_valid_in = 1'b1;
                     out_kind_in  = KindBurst;
                     out_id_in    = '0;
                     out_len_in   = '0;
                     out_idx_in   = '0;
                     out_byte_in  = '0;
                     out_err_in   = fail_next;
                     out_last_in  = 1'b1;
                     res_cnt_in   = res_cnt_ff + ResCntW'(1);
                  end
                  fail_in = '0;
                  rd_in   = fs_ff + RingAw'(1);
                  seq_in  = SEQ_FETCH;
               end
            end else begin
               fail_in = fail_next;
               rd_in   = fs_ff + RingAw'(1);
               seq_in  = SEQ_FETCH;
            end
         end
         SEQ_EM_RD: begin
            ram_re    = 1'b1;
            ram_raddr = fs_ff + RingAw'(4) + step_ff[RingAw-1:0];
            seq_in    = SEQ_EM_WR;
         end
         SEQ_EM_WR: begin
            if (!emit_ok || slot_free) begin
               if (emit_ok) begin
                  out_valid_in = 1'b1;
                  out_kind_in  = KindPayload;
                  out_id_in    = held_id_ff;
                  out_len_in   = len6;
                  out_idx_in   = step_ff[IndexW-1:0];
                  out_byte_in  = ram_rdata;
                  out_err_in   = '0;
                  out_last_in  = (step_ff + (CountW+1)'(1) == (CountW+1)'(len6));
                  res_cnt_in   = res_cnt_ff + ResCntW'(1);
               end
               step_in = step_ff + (CountW+1)'(1);
               if (step_ff + (CountW+1)'(1) == (CountW+1)'(len6)) begin
                  seq_in = SEQ_FETCH;
               end else begin
                  seq_in = SEQ_EM_RD;
               end
            end
         end
         default: seq_in = SEQ_IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff       <= SEQ_IDLE;
         scan_ff      <= SCAN_WAIT1;
         wr_ff        <= '0;
         rd_ff        <= '0;
         fs_ff        <= '0;
         held_id_ff   <= '0;
         held_len_ff  <= '0;
         pay_cnt_ff   <= '0;
         rx_check_ff  <= '0;
         fail_ff      <= '0;
         step_ff      <= '0;
         res_cnt_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         seq_ff       <= seq_in;
         scan_ff      <= scan_in;
         wr_ff        <= wr_in;
         rd_ff        <= rd_in;
         fs_ff        <= fs_in;
         held_id_ff   <= held_id_in;
         held_len_ff  <= held_len_in;
         pay_cnt_ff   <= pay_cnt_in;
         rx_check_ff  <= rx_check_in;
         fail_ff      <= fail_in;
         step_ff      <= step_in;
         res_cnt_ff   <= res_cnt_in;
         out_valid_ff <= out_valid_in;
      end
      out_kind_ff <= out_kind_in;
      out_id_ff   <= out_id_in;
      out_len_ff  <= out_len_in;
      out_idx_ff  <= out_idx_in;
      out_byte_ff <= out_byte_in;
      out_err_ff  <= out_err_in;
      out_last_ff <= out_last_in;
   end

   assign req_stall        = (seq_ff != SEQ_IDLE);
   assign rsp_valid        = out_valid_ff;
   assign rsp_kind         = out_kind_ff;
   assign rsp_frame_id     = out_id_ff;
   assign rsp_frame_length = out_len_ff;
   assign rsp_byte_index   = out_idx_ff;
   assign rsp_payload_byte = out_byte_ff;
   assign rsp_error_count  = out_err_ff;
   assign rsp_last         = out_last_ff;

endmodule

FILE: sim/crc_framed_byte_receiver_tb.sv
// ----------------------------------------------------------------------------
// crc_framed_byte_receiver_tb
// Drives framed and corrupted byte streams into the receiver, predicts the
// payload, empty-frame and burst-error results, and checks them in order.
// ----------------------------------------------------------------------------
module crc_framed_byte_receiver_tb;
   import cfbr_pkg::*;

   // scanner states of the predictor
   typedef enum logic [2:0] {
      ScanWait1, ScanWait2, ScanId, ScanLen, ScanPay, ScanCrcLo, ScanCrcHi
   } scan_type;

   // one expected or observed result
   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  frame_id;
      logic [5:0]  frame_length;
      logic [4:0]  byte_index;
      logic [7:0]  payload_byte;
      logic [15:0] error_count;
      logic        last;
   } frame_result_type;

   // frame decoder prediction and ordered result check
   class frame_scoreboard;
      cfg_type          cfg;
      scan_type         scan;
      logic [7:0]       id_hold;
      logic [7:0]       len_hold;
      int               pay_cnt;
      logic [15:0]      rx_crc;
      logic [15:0]      fail_cnt;
      logic [7:0]       pay_mem [MaxPayload];
      logic [7:0]       raw_mem [$];
      frame_result_type pending [$];
      int               errors;
      int               burst_cnt;

      function void clear();
         cfg = '{8'hAA, 8'h55, 16'hFFFF, 16'h1021, 6'd32, 16'd5};
         scan = ScanWait1;
         id_hold = '0;
         len_hold = '0;
         pay_cnt = 0;
         rx_crc = '0;
         fail_cnt = '0;
         raw_mem.delete();
         pending.delete();
         errors = 0;
         burst_cnt = 0;
      endfunction

      function logic [15:0] crc8(logic [15:0] c, logic [7:0] d);
         c = c ^ {d, 8'h00};
         for (int k = 0; k < 8; k++) begin
            if (c[15]) c = {c[14:0], 1'b0} ^ cfg.crc_polynomial;
            else c = {c[14:0], 1'b0};
         end
         return c;
      endfunction

      function void push_result(frame_result_type r);
         pending.push_back(r);
      endfunction

      function void start_raw(logic [7:0] c);
         raw_mem.delete();
         raw_mem.push_back(c);
         scan = ScanWait2;
      endfunction

      // replay a failed frame from the byte after its first
      function void replay();
         logic [7:0] saved [$];
         saved = raw_mem;
         scan = ScanWait1;
         raw_mem.delete();
         for (int i = 1; i < saved.size(); i++) note_byte(saved[i]);
      endfunction

      function void note_byte(logic [7:0] c);
         logic [15:0] crc;
         int lim;
         frame_result_type r;
         case (scan)
            ScanWait2: begin
               raw_mem.push_back(c);
               if (c == cfg.preamble_second) scan = ScanId;
               else if (c == cfg.preamble_first) start_raw(c);
               else begin
                  scan = ScanWait1;
                  raw_mem.delete();
               end
            end
            ScanId: begin
               raw_mem.push_back(c);
               id_hold = c;
               scan = ScanLen;
            end
            ScanLen: begin
               raw_mem.push_back(c);
               len_hold = c;
               pay_cnt = 0;
               lim = (cfg.payload_limit > MaxPayload) ? MaxPayload : cfg.payload_limit;
               if (len_hold > lim) replay();
               else scan = (len_hold > 0) ? ScanPay : ScanCrcLo;
            end
            ScanPay: begin
               raw_mem.push_back(c);
               pay_mem[pay_cnt] = c;
               pay_cnt++;
               if (pay_cnt >= len_hold) scan = ScanCrcLo;
            end
            ScanCrcLo: begin
               raw_mem.push_back(c);
               rx_crc = {8'h00, c};
               scan = ScanCrcHi;
            end
            ScanCrcHi: begin
               raw_mem.push_back(c);
               rx_crc[15:8] = c;
               crc = crc8(cfg.crc_start, id_hold);
               crc = crc8(crc, len_hold);
               for (int i = 0; i < len_hold; i++) crc = crc8(crc, pay_mem[i]);
               if (crc == rx_crc) begin
                  fail_cnt = '0;
                  scan = ScanWait1;
                  raw_mem.delete();
                  if (len_hold == 0) begin
                     r = '{KindEmpty, id_hold, 6'd0, 5'd0, 8'd0, 16'd0, 1'b1};
                     push_result(r);
                  end else begin
                     for (int i = 0; i < len_hold; i++) begin
                        r = '{KindPayload, id_hold, len_hold[5:0], i[4:0], pay_mem[i],
                              16'd0, (i + 1 == len_hold)};
                        push_result(r);
                     end
                  end
               end else begin
                  fail_cnt = fail_cnt + 16'd1;
                  if (fail_cnt >= cfg.burst_limit) begin
                     r = '{KindBurst, 8'd0, 6'd0, 5'd0, 8'd0, fail_cnt, 1'b1};
                     push_result(r);
                     burst_cnt++;
                     fail_cnt = '0;
                  end
                  replay();
               end
            end
            default: begin
               if (c == cfg.preamble_first) start_raw(c);
               else scan = ScanWait1;
            end
         endcase
      endfunction

      function void check_result(frame_result_type act);
         frame_result_type exp_r;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result %h", $realtime, act);
            errors++;
            return;
         end
         exp_r = pending.pop_front();
         if (exp_r.kind != act.kind)
            $display("%0t: kind exp %0d act %0d", $realtime, exp_r.kind, act.kind);
         if (exp_r.frame_id != act.frame_id)
            $display("%0t: frame_id exp %0h act %0h", $realtime, exp_r.frame_id,
                     act.frame_id);
         if (exp_r.frame_length != act.frame_length)
            $display("%0t: frame_length exp %0d act %0d", $realtime,
                     exp_r.frame_length, act.frame_length);
         if (exp_r.byte_index != act.byte_index)
            $display("%0t: byte_index exp %0d act %0d", $realtime, exp_r.byte_index,
                     act.byte_index);
         if (exp_r.payload_byte != act.payload_byte)
            $display("%0t: payload_byte exp %0h act %0h", $realtime,
                     exp_r.payload_byte, act.payload_byte);
         if (exp_r.error_count != act.error_count)
            $display("%0t: error_count exp %0d act %0d", $realtime,
                     exp_r.error_count, act.error_count);
         if (exp_r.last != act.last)
            $display("%0t: last exp %0d act %0d", $realtime, exp_r.last, act.last);
         if (exp_r != act) errors++;
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_rx_byte;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [1:0]  rsp_kind;
   logic [7:0]  rsp_frame_id;
   logic [5:0]  rsp_frame_length;
   logic [4:0]  rsp_byte_index;
   logic [7:0]  rsp_payload_byte;
   logic [15:0] rsp_error_count;
   logic        rsp_last;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [15:0] csr_wdata;

   frame_scoreboard board;
   int  idle_cycles;
   int  stall_mode;
   int  fed_count;
   bit  timed_out;
   logic [7:0] stream_q [$];

   localparam int WatchdogLimit = 20000;

   crc_framed_byte_receiver DUT (.*);

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver stall pattern: modes of no stall, light, heavy and periodic
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= ($urandom_range(0, 3) != 0);
            default: rsp_stall <= ((($time / 10) % 5) < 2);
         endcase
      end
   end

   initial stall_mode = 0;

   // result monitor and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            board.check_result('{rsp_kind, rsp_frame_id, rsp_frame_length,
                                 rsp_byte_index, rsp_payload_byte,
                                 rsp_error_count, rsp_last});
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall)
             || (csr_valid && csr_ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
      end
   end

   always @(posedge clock) begin
      if (idle_cycles >= WatchdogLimit && !timed_out) begin
         timed_out = 1'b1;
         $display("status: fail");
         $finish;
      end
   end

   // one register write transaction
   task automatic write_reg(logic [2:0] idx, logic [15:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         RegPreambleFirst:  board.cfg.preamble_first = val[7:0];
         RegPreambleSecond: board.cfg.preamble_second = val[7:0];
         RegCrcStart:       board.cfg.crc_start = val;
         RegCrcPolynomial:  board.cfg.crc_polynomial = val;
         RegPayloadLimit:   board.cfg.payload_limit = val[5:0];
         default:           board.cfg.burst_limit = val;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // send the queued bytes, in bursts with random gaps when gaps is set
   task automatic send_stream(bit gaps);
      int burst;
      burst = 0;
      while (stream_q.size() > 0) begin
         if (gaps && burst == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge clock);
            burst = $urandom_range(1, 12);
         end
         req_valid <= 1'b1;
         req_rx_byte <= stream_q[0];
         do @(posedge clock); while (req_stall);
         board.note_byte(stream_q.pop_front());
         fed_count++;
         if (burst > 0) burst--;
         @(negedge clock);
      end
      req_valid <= 1'b0;
   endtask

   // wait until every predicted result has come and the block is idle
   task automatic drain();
      while (board.pending.size() > 0) @(posedge clock);
      repeat (400) @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // append a frame; corrupt flips the crc
   task automatic add_frame(logic [7:0] id, int len, bit corrupt, bit rand_pay);
      logic [15:0] crc;
      logic [7:0]  b;
      stream_q.push_back(board.cfg.preamble_first);
      stream_q.push_back(board.cfg.preamble_second);
      stream_q.push_back(id);
      stream_q.push_back(len[7:0]);
      crc = board.crc8(board.cfg.crc_start, id);
      crc = board.crc8(crc, len[7:0]);
      for (int i = 0; i < len; i++) begin
         b = rand_pay ? 8'($urandom_range(0, 255)) : ((i % 2) ? 8'hFF : 8'h00);
         stream_q.push_back(b);
         crc = board.crc8(crc, b);
      end
      if (corrupt) crc = crc ^ (16'h1 << $urandom_range(0, 15));
      stream_q.push_back(crc[7:0]);
      stream_q.push_back(crc[15:8]);
   endtask

   task automatic add_random_frames(int n);
      int pick;
      for (int k = 0; k < n; k++) begin
         pick = $urandom_range(0, 9);
         if (pick < 6)
            add_frame(8'($urandom_range(0, 255)), $urandom_range(0, 8), 1'b0, 1'b1);
         else if (pick < 8)
            add_frame(8'($urandom_range(0, 255)), $urandom_range(0, 6), 1'b1, 1'b1);
         else
            repeat ($urandom_range(1, 4)) stream_q.push_back(8'($urandom_range(0, 255)));
      end
   endtask

   initial begin
      board = new();
      board.clear();
      reset = 1'b1;
      req_valid = 1'b0;
      req_rx_byte = 8'h00;
      csr_valid = 1'b0;
      csr_index = RegPreambleFirst;
      csr_wdata = 16'h0000;
      idle_cycles = 0;
      fed_count = 0;
      timed_out = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty frame, longest frame, overlong length, broken preamble
      add_frame(8'h00, 0, 1'b0, 1'b0);
      add_frame(8'hFF, 32, 1'b0, 1'b0);
      stream_q.push_back(8'hAA);
      stream_q.push_back(8'hAA);
      stream_q.push_back(8'h55);
      stream_q.push_back(8'h12);
      stream_q.push_back(8'd33);
      stream_q.push_back(8'hAA);
      stream_q.push_back(8'h07);
      send_stream(1'b0);
      drain();

      // burst limit of one and an explicit overlong payload limit
      write_reg(RegBurstLimit, 16'd1);
      write_reg(RegPayloadLimit, 16'd63);
      add_frame(8'h3C, 2, 1'b1, 1'b1);
      add_frame(8'h3D, 1, 1'b0, 1'b1);
      send_stream(1'b0);
      drain();

      // zero burst limit, zero payload limit, all-ones preambles
      write_reg(RegBurstLimit, 16'd0);
      write_reg(RegPayloadLimit, 16'd0);
      write_reg(RegPreambleFirst, 16'h00FF);
      write_reg(RegPreambleSecond, 16'h00FF);
      write_reg(RegCrcStart, 16'h0000);
      write_reg(RegCrcPolynomial, 16'hFFFF);
      add_frame(8'h01, 0, 1'b0, 1'b1);
      add_frame(8'h02, 0, 1'b1, 1'b1);
      add_frame(8'h03, 1, 1'b0, 1'b1);
      send_stream(1'b0);
      drain();

      // random phases under several settings
      for (int ph = 0; ph < 4; ph++) begin
         stall_mode = ph;
         write_reg(RegPreambleFirst, (ph == 1) ? 16'h0000 : 16'($urandom_range(0, 255)));
         write_reg(RegPreambleSecond, (ph == 1) ? 16'h0000 : 16'($urandom_range(0, 255)));
         write_reg(RegCrcStart, (ph == 0) ? 16'hFFFF : 16'($urandom_range(0, 65535)));
         write_reg(RegCrcPolynomial, (ph == 0) ? 16'h1021 : 16'($urandom_range(0, 65535)));
         write_reg(RegPayloadLimit, (ph == 3) ? 16'd32 : 16'($urandom_range(4, 40)));
         write_reg(RegBurstLimit, (ph == 2) ? 16'hFFFF : 16'($urandom_range(1, 3)));
         add_random_frames(1);
         send_stream(1'b1);
         drain();
      end
      stall_mode = 1;
      while (board.burst_cnt < 3 && fed_count < 2000) begin
         write_reg(RegBurstLimit, 16'd2);
         add_frame(8'($urandom_range(0, 255)), $urandom_range(0, 3), 1'b1, 1'b1);
         add_frame(8'($urandom_range(0, 255)), $urandom_range(0, 3), 1'b1, 1'b1);
         send_stream(1'b1);
         drain();
      end

      if (board.errors == 0 && board.pending.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

FILE: files.f
sv/cfbr_pkg.sv
sv/cfbr_ram.sv
sv/cfbr_crc_unit.sv
sv/cfbr_csr.sv
sv/crc_framed_byte_receiver.sv
sim/crc_framed_byte_receiver_tb.sv
